FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

FILE: sv/lfa_pkg.sv
// Shared types and constants for the LRU frame allocator.
// No dependencies.
package lfa_pkg;

   localparam int NUM_FRAMES_DEF = 16;
   localparam int AGE_W          = 16;
   localparam int TYPE_W         = 2;
   localparam int FRAME_W        = 4;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [AGE_W-1:0] AGE_MAX        = '1;
   localparam logic [AGE_W-1:0] PROT_AGE_RESET = AGE_W'(16);

   // Register index taken from paddr above the byte offset.
   localparam logic REG_PROT_AGE = 1'b0;

   localparam logic [TYPE_W-1:0] REQ_ACCESS  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   typedef enum logic [1:0] {
      OP_TOUCH,
      OP_ALLOC,
      OP_RELEASE
   } op_type;

   typedef struct packed {
      logic   scan;
      logic   apply;
      logic   first;
      op_type op;
   } head_ctl_type;

endpackage

FILE: sv/lfa_cell.sv
// One frame slot of the rotating ring: free bit and age counter.
// Depends on lfa_pkg.
module lfa_cell import lfa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic             in_free,
   input  logic [AGE_W-1:0] in_age,
   output logic             free,
   output logic [AGE_W-1:0] age
);

   logic             free_ff, free_in;
   logic [AGE_W-1:0] age_ff, age_in;

   always_comb begin
      free_in = shift ? in_free : free_ff;
      age_in  = shift ? in_age  : age_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= 1'b1;
         age_ff  <= '0;
      end else begin
         free_ff <= free_in;
         age_ff  <= age_in;
      end
   end

   assign free = free_ff;
   assign age  = age_ff;

endmodule

FILE: sv/lfa_head.sv
// Ring head unit: searches for a free frame and a victim, and applies
// touch/allocate/release updates to the slot passing through. Depends on lfa_pkg.
module lfa_head import lfa_pkg::*; #(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF,
   localparam int IDX_W = $clog2(NUM_FRAMES)
) (
   input  logic               clock,
   input  logic               reset,
   input  head_ctl_type       ctl,
   input  logic [IDX_W-1:0]   idx,
   input  logic [IDX_W-1:0]   target,
   input  logic [AGE_W-1:0]   prot_age,
   input  logic               head_free,
   input  logic [AGE_W-1:0]   head_age,
   output logic               new_free,
   output logic [AGE_W-1:0]   new_age,
   output logic               found_next,
   output logic [IDX_W-1:0]   free_idx_next,
   output logic [IDX_W-1:0]   victim_next
);

   logic               found_ff, have_best_ff;
   logic [IDX_W-1:0]   free_idx_ff, victim_ff;
   logic [AGE_W-1:0]   best_ff;
   logic               have_best_next;
   logic [AGE_W-1:0]   best_next;
   logic               hit, aged;

   always_comb begin
      found_next     = ctl.first ? 1'b0 : found_ff;
      have_best_next = ctl.first ? 1'b0 : have_best_ff;
      free_idx_next  = free_idx_ff;
      victim_next    = victim_ff;
      best_next      = best_ff;
      if (ctl.scan) begin
         if (!found_next && head_free) begin
            found_next    = 1'b1;
            free_idx_next = idx;
         end
         // Frame 0 is never skipped, so a victim always exists.
         if ((!have_best_next || head_age > best_next) &&
             !(idx != '0 && head_age == prot_age)) begin
            have_best_next = 1'b1;
            best_next      = head_age;
            victim_next    = idx;
         end
      end
   end

   always_comb begin
      hit      = (idx == target);
      aged     = !head_free && head_age != AGE_MAX;
      new_free = head_free;
      new_age  = head_age;
      if (ctl.apply) begin
         case (ctl.op)
            OP_TOUCH: begin
               if (hit) new_age = '0;
               else if (aged) new_age = head_age + AGE_W'(1);
            end
            OP_ALLOC: begin
               if (hit) begin
                  new_age  = '0;
                  new_free = 1'b0;
               end else if (aged) begin
                  new_age = head_age + AGE_W'(1);
               end
            end
            OP_RELEASE: begin
               if (hit) begin
                  new_age  = '0;
                  new_free = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         have_best_ff <= 1'b0;
      end else if (ctl.scan) begin
         found_ff     <= found_next;
         have_best_ff <= have_best_next;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.scan) begin
         free_idx_ff <= free_idx_next;
         victim_ff   <= victim_next;
         best_ff     <= best_next;
      end
   end

endmodule

FILE: sv/lru_frame_allocator_top.sv
// LRU page frame allocator: ring of NUM_FRAMES cells rotated past one head unit.
// Access/release take one update pass, allocate a scan pass then an update
// pass, and an unused code or out-of-range frame takes no pass; one request at a time.
// The ring rotation (one frame per cycle through the head) sets the rate.
// Reset (synchronous): all frames free, ages zero, protected_age = 16.
// Depends on lfa_pkg, lfa_cell, lfa_head and assert_macros.svh.
module lru_frame_allocator_top import lfa_pkg::*; #(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [TYPE_W-1:0]      req_type,
   input  logic [FRAME_W-1:0]     req_frame_index,
   // result channel, one-cycle strobe
   output logic                   rsp_valid,
   output logic [FRAME_W-1:0]     rsp_granted_frame,
   output logic                   rsp_evicted,
   // register port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   `include "assert_macros.svh"

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int GW    = (IDX_W > FRAME_W) ? IDX_W : FRAME_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_FRAMES - 1);

   // ---------------------------------------------------------------
   // Register port: protected_age is the only register.
   // ---------------------------------------------------------------
   logic [AGE_W-1:0] prot_ff, prot_in;
   logic             reg_sel;

   assign reg_sel = (paddr[CSR_ADDR_W-1] == REG_PROT_AGE);
   assign pready  = 1'b1;
   assign prdata  = reg_sel ? CSR_DATA_W'(prot_ff) : '0;

   always_comb begin
      prot_in = prot_ff;
      if (psel && penable && pwrite && reg_sel) prot_in = pwdata[AGE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) prot_ff <= PROT_AGE_RESET;
      else       prot_ff <= prot_in;
   end

   // ---------------------------------------------------------------
   // Control: state, ring position, request target and result.
   // ---------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   target_ff, target_in;
   op_type             op_ff, op_in;
   logic [FRAME_W-1:0] grant_ff, grant_in;
   logic               ev_ff, ev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic               rsp_ev_ff, rsp_ev_in;

   logic               shift, idx_last, in_range;
   logic [GW-1:0]      fi_ext, tgt_ext;
   logic [IDX_W-1:0]   fi_idx;
   head_ctl_type       hctl;

   logic               head_new_free, found_next;
   logic [AGE_W-1:0]   head_new_age;
   logic [IDX_W-1:0]   free_idx_next, victim_next;

   assign fi_ext   = GW'(req_frame_index);
   assign fi_idx   = fi_ext[IDX_W-1:0];
   assign in_range = (32'(req_frame_index) < NUM_FRAMES);
   assign idx_last = (idx_ff == IDX_LAST);
   assign shift    = (state_ff != ST_IDLE);
   assign busy     = shift;

   assign hctl.scan  = (state_ff == ST_SCAN);
   assign hctl.apply = (state_ff == ST_APPLY);
   assign hctl.first = (idx_ff == '0);
   assign hctl.op    = op_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      target_in    = target_ff;
      op_in        = op_ff;
      grant_in     = grant_ff;
      ev_in        = ev_ff;
      rsp_valid_in = 1'b0;
      rsp_frame_in = rsp_frame_ff;
      rsp_ev_in    = rsp_ev_ff;
      tgt_ext      = '0;
      // advance the ring one slot per busy cycle, wrap back to home
      if (shift) idx_in = idx_last ? '0 : idx_ff + IDX_W'(1);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               grant_in  = req_frame_index;
               ev_in     = 1'b0;
               target_in = fi_idx;
               case (req_type) inside
                  REQ_ACCESS, REQ_RELEASE: begin
                     if (in_range) begin
                        op_in    = (req_type == REQ_ACCESS) ? OP_TOUCH : OP_RELEASE;
                        state_in = ST_APPLY;
                     end else begin
                        // out-of-range frame: echo it, change nothing
                        rsp_valid_in = 1'b1;
                        rsp_frame_in = req_frame_index;
                        rsp_ev_in    = 1'b0;
                     end
                  end
                  REQ_ALLOC: begin
                     op_in    = OP_ALLOC;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     // unused request code: echo the frame, no effect
                     rsp_valid_in = 1'b1;
                     rsp_frame_in = req_frame_index;
                     rsp_ev_in    = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (idx_last) begin
               // lowest free frame wins; otherwise evict the oldest
               target_in = found_next ? free_idx_next : victim_next;
               ev_in     = !found_next;
               tgt_ext   = GW'(target_in);
               grant_in  = tgt_ext[FRAME_W-1:0];
               state_in  = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (idx_last) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = grant_ff;
               rsp_ev_in    = ev_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request payload and result hold registers
   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      op_ff        <= op_in;
      grant_ff     <= grant_in;
      ev_ff        <= ev_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_ev_ff    <= rsp_ev_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_frame = rsp_frame_ff;
   assign rsp_evicted       = rsp_ev_ff;

   // ---------------------------------------------------------------
   // Ring of cells: cell 0 is the head; its updated contents enter at
   // the tail, so after a full turn of the ring every frame is home again.
   // ---------------------------------------------------------------
   logic             cell_free [NUM_FRAMES];
   logic [AGE_W-1:0] cell_age  [NUM_FRAMES];

   for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
      logic             nxt_free;
      logic [AGE_W-1:0] nxt_age;
      if (i == NUM_FRAMES - 1) begin : g_tail
         assign nxt_free = head_new_free;
         assign nxt_age  = head_new_age;
      end else begin : g_mid
         assign nxt_free = cell_free[i+1];
         assign nxt_age  = cell_age[i+1];
      end
      lfa_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .in_free (nxt_free),
         .in_age  (nxt_age),
         .free    (cell_free[i]),
         .age     (cell_age[i])
      );
   end

   lfa_head #(.NUM_FRAMES(NUM_FRAMES)) u_head (
      .clock         (clock),
      .reset         (reset),
      .ctl           (hctl),
      .idx           (idx_ff),
      .target        (target_ff),
      .prot_age      (prot_ff),
      .head_free     (cell_free[0]),
      .head_age      (cell_age[0]),
      .new_free      (head_new_free),
      .new_age       (head_new_age),
      .found_next    (found_next),
      .free_idx_next (free_idx_next),
      .victim_next   (victim_next)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `ASSERT_NEVER(a_no_rsp_while_busy, clock, reset, rsp_valid && busy)
   `ASSERT_CLK(a_idle_ring_home, clock, reset, (state_ff == ST_IDLE) |-> (idx_ff == '0))
   `ASSERT_CLK(a_scan_to_apply, clock, reset, (hctl.scan && idx_last) |=> hctl.apply)

endmodule

FILE: verif/lru_frame_allocator_top_tb.sv
// Self-checking testbench for lru_frame_allocator_top: directed and random request
// streams, with every grant checked against an in-bench frame table model.
// Depends on lfa_pkg and the lru_frame_allocator_top RTL.
module lru_frame_allocator_top_tb import lfa_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NFRAMES = NUM_FRAMES_DEF;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] PROT_AGE_ADDR = CSR_ADDR_W'(4 * int'(REG_PROT_AGE));

   // One step of the script: a request, a protected_age write, or a full drain.
   typedef enum logic [1:0] {
      ACT_REQ,
      ACT_CSR,
      ACT_DRAIN
   } act_kind_type;

   typedef struct packed {
      act_kind_type            kind;
      logic [TYPE_W-1:0]       rtype;
      logic [FRAME_W-1:0]      frame;
      logic [CSR_DATA_W-1:0]   wdata;
      logic [2:0]              gap;
   } script_step_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               evicted;
   } grant_type;

   typedef enum logic [3:0] {
      DRV_FETCH,
      DRV_GAP,
      DRV_REQ,
      DRV_DRAIN,
      DRV_CSR_WAIT,
      DRV_WR_SETUP,
      DRV_WR_ACCESS,
      DRV_RD_SETUP,
      DRV_RD_ACCESS
   } drv_state_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [TYPE_W-1:0]     req_type = '0;
   logic [FRAME_W-1:0]    req_frame_index = '0;
   logic                  rsp_valid;
   logic [FRAME_W-1:0]    rsp_granted_frame;
   logic                  rsp_evicted;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lru_frame_allocator_top #(.NUM_FRAMES(NFRAMES)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_frame_index   (req_frame_index),
      .rsp_valid         (rsp_valid),
      .rsp_granted_frame (rsp_granted_frame),
      .rsp_evicted       (rsp_evicted),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Script of pending steps, filled up front and drained by the driver.
   script_step_type op_script[$];
   // Grants still owed by the block, oldest first.
   grant_type       pending_grants[$];

   // Frame table as the block should hold it.
   logic             frame_vacant[NFRAMES];
   logic [AGE_W-1:0] frame_age_mdl[NFRAMES];
   logic [AGE_W-1:0] prot_age_mdl;

   int              error_count = 0;
   logic            req_taken = 1'b0;
   drv_state_type   drv_state = DRV_FETCH;
   int              gap_left = 0;
   script_step_type cur_step;

   initial begin
      forever #4 clock = ~clock;
   end

   // Hold reset from the start, then release it off a falling edge.
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("lru_frame_allocator_top: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Frame table model
   // ---------------------------------------------------------------------------

   // Zero the age of frame f and age every other occupied frame, saturating.
   function automatic void touch_frame_mdl(int f);
      for (int i = 0; i < NFRAMES; i++) begin
         if (i == f) begin
            frame_age_mdl[i] = '0;
         end else if (!frame_vacant[i] && frame_age_mdl[i] != AGE_MAX) begin
            frame_age_mdl[i] = frame_age_mdl[i] + AGE_W'(1);
         end
      end
   endfunction

   // Apply one request to the model and return the grant it must produce.
   function automatic grant_type predict_grant(logic [TYPE_W-1:0] kind,
                                               logic [FRAME_W-1:0] fi);
      grant_type g;
      int        victim;
      int        best;
      bit        found;
      g.frame   = fi;
      g.evicted = 1'b0;
      case (kind)
         REQ_ACCESS: begin
            if (int'(fi) < NFRAMES) touch_frame_mdl(int'(fi));
         end
         REQ_ALLOC: begin
            found  = 1'b0;
            victim = 0;
            for (int i = 0; i < NFRAMES; i++) begin
               if (!found && frame_vacant[i]) begin
                  victim = i;
                  found  = 1'b1;
               end
            end
            if (!found) begin
               // Oldest frame wins, lowest index on a tie; frame 0 is never protected.
               best = -1;
               for (int i = 0; i < NFRAMES; i++) begin
                  if (int'(frame_age_mdl[i]) > best &&
                      !(i != 0 && frame_age_mdl[i] == prot_age_mdl)) begin
                     best   = int'(frame_age_mdl[i]);
                     victim = i;
                  end
               end
               frame_age_mdl[victim] = '0;
               frame_vacant[victim]  = 1'b1;
               g.evicted = 1'b1;
            end
            touch_frame_mdl(victim);
            frame_vacant[victim] = 1'b0;
            g.frame = FRAME_W'(victim);
         end
         REQ_RELEASE: begin
            if (int'(fi) < NFRAMES) begin
               frame_age_mdl[fi] = '0;
               frame_vacant[fi]  = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return g;
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: sample at the rising edge, check grants, track accepted requests
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         for (int i = 0; i < NFRAMES; i++) begin
            frame_vacant[i]  = 1'b1;
            frame_age_mdl[i] = '0;
         end
         prot_age_mdl = PROT_AGE_RESET;
         pending_grants.delete();
         req_taken = 1'b0;
      end else begin
         // Check the result first: it always belongs to an earlier request.
         if (rsp_valid) begin
            if (pending_grants.size() == 0) begin
               error_count++;
               $error("unexpected grant: frame %0d evicted %0d",
                      rsp_granted_frame, rsp_evicted);
            end else begin
               want = pending_grants.pop_front();
               if (rsp_granted_frame !== want.frame) begin
                  error_count++;
                  $error("granted_frame: expected %0d, actual %0d",
                         want.frame, rsp_granted_frame);
               end
               if (rsp_evicted !== want.evicted) begin
                  error_count++;
                  $error("evicted: expected %0d, actual %0d", want.evicted, rsp_evicted);
               end
            end
         end
         // Predict each request at the edge that accepts it.
         if (start && !busy) begin
            pending_grants.push_back(predict_grant(req_type, req_frame_index));
            req_taken = 1'b1;
         end else begin
            req_taken = 1'b0;
         end
         // Register port: track writes, check read-back.
         if (psel && penable && pready) begin
            if (pwrite) begin
               prot_age_mdl = pwdata[AGE_W-1:0];
            end else if (prdata !== {{(CSR_DATA_W-AGE_W){1'b0}}, prot_age_mdl}) begin
               error_count++;
               $error("protected_age: expected %0d, actual %0d", prot_age_mdl, prdata);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driver: change inputs at the falling edge, one script step at a time
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         // Retire the step that completed at the last rising edge.
         case (drv_state)
            DRV_REQ: begin
               if (req_taken) begin
                  start     = 1'b0;
                  drv_state = DRV_FETCH;
               end
            end
            DRV_WR_SETUP: begin
               penable   = 1'b1;
               drv_state = DRV_WR_ACCESS;
            end
            DRV_WR_ACCESS: begin
               // pready is always high, so the write is done; read it back.
               penable   = 1'b0;
               pwrite    = 1'b0;
               drv_state = DRV_RD_SETUP;
            end
            DRV_RD_SETUP: begin
               penable   = 1'b1;
               drv_state = DRV_RD_ACCESS;
            end
            DRV_RD_ACCESS: begin
               psel      = 1'b0;
               penable   = 1'b0;
               drv_state = DRV_FETCH;
            end
            default: begin
            end
         endcase

         // Fetch the next step and draw down its idle gap.
         if (drv_state == DRV_FETCH && op_script.size() != 0) begin
            cur_step  = op_script.pop_front();
            gap_left  = int'(cur_step.gap);
            drv_state = DRV_GAP;
         end
         if (drv_state == DRV_GAP) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               case (cur_step.kind)
                  ACT_REQ: begin
                     req_type        = cur_step.rtype;
                     req_frame_index = cur_step.frame;
                     start           = 1'b1;
                     drv_state       = DRV_REQ;
                  end
                  ACT_CSR: drv_state = DRV_CSR_WAIT;
                  default: drv_state = DRV_DRAIN;
               endcase
            end
         end

         // Hold until every owed grant is in and the block is idle.
         if (drv_state == DRV_DRAIN && pending_grants.size() == 0 && !busy)
            drv_state = DRV_FETCH;
         if (drv_state == DRV_CSR_WAIT && pending_grants.size() == 0 && !busy) begin
            psel      = 1'b1;
            penable   = 1'b0;
            pwrite    = 1'b1;
            paddr     = PROT_AGE_ADDR;
            pwdata    = cur_step.wdata;
            drv_state = DRV_WR_SETUP;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Script building
   // ---------------------------------------------------------------------------
   function automatic void add_req(logic [TYPE_W-1:0] t, logic [FRAME_W-1:0] f, int g);
      script_step_type s;
      s       = '0;
      s.kind  = ACT_REQ;
      s.rtype = t;
      s.frame = f;
      s.gap   = 3'(g);
      op_script.push_back(s);
   endfunction

   // Upper data bits are random; only the low sixteen hold the register.
   function automatic void add_csr(logic [AGE_W-1:0] v);
      script_step_type s;
      s       = '0;
      s.kind  = ACT_CSR;
      s.wdata = {16'($urandom()), v};
      op_script.push_back(s);
   endfunction

   function automatic void add_drain();
      script_step_type s;
      s      = '0;
      s.kind = ACT_DRAIN;
      op_script.push_back(s);
   endfunction

   initial begin
      int               pick;
      int               rel_pct;
      int               gap_mode;
      int               g;
      logic [TYPE_W-1:0] t;
      logic [AGE_W-1:0] pv;

      // Directed: free-frame access and release, unused code, fill, evict, protect.
      add_req(REQ_ACCESS, 4'd0, 0);
      add_req(REQ_RELEASE, 4'd15, 0);
      add_req(REQ_UNUSED, 4'd15, 0);
      add_req(REQ_UNUSED, 4'd0, 1);
      for (int i = 0; i < NFRAMES; i++)
         add_req(REQ_ALLOC, (i % 2) ? 4'hF : 4'h0, 0);
      add_req(REQ_ACCESS, 4'd15, 0);
      add_req(REQ_ACCESS, 4'd0, 2);
      add_req(REQ_ALLOC, 4'd9, 0);
      add_req(REQ_RELEASE, 4'd7, 0);
      add_req(REQ_ALLOC, 4'd3, 0);
      add_csr('0);
      add_req(REQ_ALLOC, 4'd0, 0);
      add_csr(AGE_MAX);
      add_req(REQ_ALLOC, 4'd0, 0);

      // Random phases: each with its own protected_age, release rate and idling.
      for (int phase = 0; phase < 14; phase++) begin
         case ($urandom_range(0, 7))
            0: pv = '0;
            1: pv = AGE_MAX;
            2: pv = PROT_AGE_RESET;
            3: pv = AGE_W'($urandom_range(1, 4));
            4: pv = AGE_W'($urandom_range(0, 40));
            5: pv = AGE_W'($urandom_range(5, 12));
            6: pv = AGE_W'($urandom());
            default: pv = AGE_W'($urandom_range(13, 20));
         endcase
         add_csr(pv);
         case ($urandom_range(0, 2))
            0: rel_pct = 0;
            1: rel_pct = 5;
            default: rel_pct = 20;
         endcase
         gap_mode = $urandom_range(0, 2);
         for (int n = 0; n < 100; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) t = REQ_UNUSED;
            else if (pick < 4 + rel_pct) t = REQ_RELEASE;
            else if (pick < 55) t = REQ_ALLOC;
            else t = REQ_ACCESS;
            case (gap_mode)
               0: g = 0;
               1: g = $urandom_range(0, 6);
               default: g = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
            endcase
            add_req(t, FRAME_W'($urandom_range(0, NFRAMES - 1)), g);
            // Let the pipeline run dry mid-phase now and then.
            if (n == 50 && (phase % 2) == 1) add_drain();
         end
      end

      // Full table: fill every frame, age the rest against one hot frame, evict.
      add_csr(AGE_MAX);
      for (int i = 0; i < NFRAMES; i++)
         add_req(REQ_ALLOC, 4'd0, 0);
      for (int i = 0; i < 40; i++)
         add_req(REQ_ACCESS, 4'd15, 0);
      for (int i = 0; i < 3; i++)
         add_req(REQ_ALLOC, 4'd0, 0);
      add_csr(AGE_MAX - AGE_W'(1));
      for (int i = 0; i < 3; i++)
         add_req(REQ_ALLOC, 4'd0, 1);
      add_req(REQ_RELEASE, 4'd3, 0);
      add_req(REQ_ACCESS, 4'd3, 0);
      add_req(REQ_ALLOC, 4'd0, 0);

      // Wait for the script to drain, then for the last grants to arrive.
      while (op_script.size() != 0 || drv_state != DRV_FETCH) @(negedge clock);
      for (int w = 0; w < 4000 && pending_grants.size() != 0; w++) @(posedge clock);
      if (pending_grants.size() != 0) begin
         error_count++;
         $error("%0d grants never arrived", pending_grants.size());
      end
      // Allow a full allocate pass for any stray late result.
      repeat (2 * NFRAMES + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("lru_frame_allocator_top: match");
      end else begin
         $display("lru_frame_allocator_top: mismatch");
      end
      $finish;
   end

endmodule
